/* hw/rtl/assert_macros.svh */
// assertion macros used by the checker file
// no dependencies; include guard below
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion with a fixed message
`define PBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("pba check failed");

// clocked assertion with its own message
`define PBA_ASSERT_MSG(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

/* hw/rtl/pba_pkg.sv */
// shared types and codes of the page bitmap allocator
// no dependencies
package pba_pkg;

  localparam int WORD_W   = 32;
  localparam int WORD_LSB = 5;
  localparam int DATA_W   = 2 * WORD_W;

  typedef logic [2:0] opcode_t;
  localparam opcode_t OP_INIT      = 3'd0;
  localparam opcode_t OP_ALLOC_K   = 3'd1;
  localparam opcode_t OP_ALLOC_U   = 3'd2;
  localparam opcode_t OP_ALLOC_TBL = 3'd3;
  localparam opcode_t OP_FREE      = 3'd4;
  localparam opcode_t OP_QUERY     = 3'd5;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_INVALID = 3'd1;
  localparam status_t ST_KOOM    = 3'd2;
  localparam status_t ST_UOOM    = 3'd3;
  localparam status_t ST_TOOM    = 3'd4;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_TOTAL    = 2'd0;
  localparam cfg_idx_t CFG_RESERVED = 2'd1;
  localparam cfg_idx_t CFG_POOL     = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DEC,
    S_IRES,
    S_IPOOL,
    S_IFREE,
    S_INIT,
    S_RD,
    S_SEG,
    S_HIT,
    S_HEND,
    S_MRD,
    S_MWR,
    S_PRD,
    S_PG,
    S_DONE
  } state_t;

  typedef struct packed {
    logic hit;
    logic word_done;
  } span_flags_t;

endpackage

/* hw/rtl/pba_ram.sv */
// generic single write port ram with registered read
// no dependencies
module pba_ram #(
  parameter int W     = 64,
  parameter int DEPTH = 2048
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                            wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                            rdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/pba_span.sv */
// shared span unit: next used bit at or above pos, run update and fit test
// depends on pba_pkg
module pba_span #(
  parameter int CW = 17
) (
  input  logic [pba_pkg::WORD_W-1:0] used_eff,
  input  logic [4:0]                 pos,
  input  logic [CW-1:0]              run,
  input  logic [CW-1:0]              cnt,
  output pba_pkg::span_flags_t       flags,
  output logic [CW-1:0]              run_nxt,
  output logic [4:0]                 pos_nxt
);

  logic [pba_pkg::WORD_W-1:0] m;
  logic [5:0]                 u;
  logic [5:0]                 span_len;
  logic [CW:0]                sum;

  always_comb begin
    m = used_eff & ~((32'h1 << pos) - 32'h1);
    u = 6'd32;
    for (int b = pba_pkg::WORD_W - 1; b >= 0; b--) begin
      if (m[b]) begin
        u = 6'(b);
      end
    end
    span_len        = u - {1'b0, pos};
    sum             = {1'b0, run} + (CW+1)'(span_len);
    flags.hit       = sum >= {1'b0, cnt};
    // word ends on a free tail or on a used top bit
    flags.word_done = u[5] | (u[4:0] == 5'd31);
    run_nxt         = u[5] ? sum[CW-1:0] : '0;
    pos_nxt         = u[4:0] + 5'd1;
  end

endmodule

/* hw/rtl/page_bitmap_allocator_core.sv */
// init: writes one bitmap word per cycle across all NUM_PAGES/32 words of the map
// alloc: reads each bitmap word scanned, then steps once per used-bit segment in it,
//   then reads and writes back each word of the granted run; free and query read the page's word
// one item at a time: the single span unit and the single write port ram set the rate
// synchronous active-low reset clears control state and loads config defaults; map contents are undefined until init
module page_bitmap_allocator_core #(
  parameter int NUM_PAGES    = 65536,
  parameter int TOP_RESERVED = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_opcode,
  input  logic [16:0] in_page_count,
  input  logic [15:0] in_page_number,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_first_page,
  output logic        out_owner_flag,
  output logic [16:0] out_free_pages,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_wdata
);

  localparam int PW    = $clog2(NUM_PAGES);
  localparam int CW    = (PW + 1 > 17) ? PW + 1 : 17;
  localparam int DEPTH = NUM_PAGES / pba_pkg::WORD_W;
  localparam int WIW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int XW    = CW - pba_pkg::WORD_LSB;

  // bits of word w whose page index is below x
  function automatic logic [pba_pkg::WORD_W-1:0] ltmask(input logic [CW-1:0] x,
                                                      input logic [WIW-1:0] w);
    logic [XW-1:0] xw;
    logic [XW-1:0] ww;
    logic [pba_pkg::WORD_W-1:0] r;
    xw = x[CW-1:pba_pkg::WORD_LSB];
    ww = XW'(w);
    if (xw > ww) begin
      r = '1;
    end else if (xw == ww) begin
      r = (32'h1 << x[4:0]) - 32'h1;
    end else begin
      r = '0;
    end
    return r;
  endfunction

  pba_pkg::state_t state_r, state_nxt;

  logic [16:0]            cfg_total_r, cfg_res_r, cfg_pool_r;
  logic [2:0]             op_r, op_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic [CW-1:0]          pg_r, pg_nxt;
  logic [CW-1:0]          lo_r, lo_nxt, hi_r, hi_nxt;
  logic [WIW-1:0]         wi_r, wi_nxt;
  logic [4:0]             pos_r, pos_nxt;
  logic [CW-1:0]          run_r, run_nxt;
  logic [CW-1:0]          start_r, start_nxt, end_r, end_nxt;
  logic [CW-1:0]          tot_r, tot_nxt, res_r, res_nxt;
  logic [CW-1:0]          usedend_r, usedend_nxt, topstart_r, topstart_nxt;
  logic [CW-1:0]          managed_r, managed_nxt, free_r, free_nxt;
  logic                   pool_en_r, pool_en_nxt;
  logic [CW-1:0]          pool_first_r, pool_first_nxt, pool_end_r, pool_end_nxt;
  logic                   tbl_pool_r, tbl_pool_nxt;
  logic [2:0]             rs_status_r, rs_status_nxt;
  logic [15:0]            rs_first_r, rs_first_nxt;
  logic                   rs_user_r, rs_user_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [2:0]             out_status_r, out_status_nxt;
  logic [15:0]            out_first_r, out_first_nxt;
  logic                   out_user_r, out_user_nxt;
  logic [16:0]            out_free_r, out_free_nxt;

  logic                         ram_we, ram_re;
  logic [WIW-1:0]               ram_waddr, ram_raddr;
  logic [pba_pkg::DATA_W-1:0]   ram_wdata, ram_rdata;
  logic [pba_pkg::WORD_W-1:0]   rd_used, rd_owner;

  logic [CW-1:0]              base, next_base, tbl_hi;
  logic                       wi_last, scan_past, mark_last, cnt_bad, pg_bad;
  logic                       pool_fit, search_fail, done_load;
  logic [CW:0]                pool_sum;
  logic [pba_pkg::WORD_W-1:0] used_eff, run_mask, init_used, owner_new;
  pba_pkg::span_flags_t       sp_flags;
  logic [CW-1:0]              sp_run;
  logic [4:0]                 sp_pos;

  assign rd_used   = ram_rdata[pba_pkg::WORD_W-1:0];
  assign rd_owner  = ram_rdata[pba_pkg::DATA_W-1:pba_pkg::WORD_W];
  assign base      = CW'({wi_r, 5'b0});
  assign next_base = CW'({(WIW+1)'(wi_r) + (WIW+1)'(1), 5'b0});
  assign wi_last   = (wi_r == WIW'(DEPTH - 1));
  assign scan_past = base >= hi_r;
  assign mark_last = next_base >= end_r;
  assign cnt_bad   = (cnt_r == '0) || (cnt_r > managed_r);
  assign pg_bad    = pg_r >= managed_r;
  assign tbl_hi    = (pool_end_r < managed_r) ? pool_end_r : managed_r;
  assign pool_sum  = {1'b0, res_r} + (CW+1)'(cfg_pool_r);
  assign pool_fit  = (res_r != '0) && (pool_sum < {1'b0, tot_r});
  assign used_eff  = rd_used | ~ltmask(hi_r, wi_r) | ltmask(lo_r, wi_r);
  assign run_mask  = ltmask(end_r, wi_r) & ~ltmask(start_r, wi_r);
  assign init_used = ltmask(usedend_r, wi_r)
                   | (ltmask(tot_r, wi_r) & ~ltmask(topstart_r, wi_r));
  assign owner_new = (op_r == pba_pkg::OP_ALLOC_U) ? (rd_owner | run_mask)
                                                    : (rd_owner & ~run_mask);
  assign search_fail = ((state_r == pba_pkg::S_RD) && scan_past)
                     || ((state_r == pba_pkg::S_SEG) && !sp_flags.hit
                         && sp_flags.word_done && wi_last);
  assign done_load = (state_r == pba_pkg::S_DONE) && (!out_valid_r || out_ready);

  pba_span #(.CW(CW)) u_span (
    .used_eff (used_eff),
    .pos      (pos_r),
    .run      (run_r),
    .cnt      (cnt_r),
    .flags    (sp_flags),
    .run_nxt  (sp_run),
    .pos_nxt  (sp_pos)
  );

  pba_ram #(.W(pba_pkg::DATA_W), .DEPTH(DEPTH)) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pba_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = pba_pkg::S_DEC;
        end
      end
      pba_pkg::S_DEC: begin
        case (op_r)
          pba_pkg::OP_INIT:      state_nxt = pba_pkg::S_IRES;
          pba_pkg::OP_ALLOC_K,
          pba_pkg::OP_ALLOC_U:   state_nxt = cnt_bad ? pba_pkg::S_DONE : pba_pkg::S_RD;
          pba_pkg::OP_ALLOC_TBL: state_nxt = pba_pkg::S_RD;
          pba_pkg::OP_FREE,
          pba_pkg::OP_QUERY:     state_nxt = pg_bad ? pba_pkg::S_DONE : pba_pkg::S_PRD;
          default:               state_nxt = pba_pkg::S_DONE;
        endcase
      end
      pba_pkg::S_IRES:  state_nxt = pba_pkg::S_IPOOL;
      pba_pkg::S_IPOOL: state_nxt = pba_pkg::S_IFREE;
      pba_pkg::S_IFREE: state_nxt = pba_pkg::S_INIT;
      pba_pkg::S_INIT: begin
        if (wi_last) begin
          state_nxt = pba_pkg::S_DONE;
        end
      end
      pba_pkg::S_RD: begin
        if (search_fail) begin
          state_nxt = tbl_pool_r ? pba_pkg::S_RD : pba_pkg::S_DONE;
        end else begin
          state_nxt = pba_pkg::S_SEG;
        end
      end
      pba_pkg::S_SEG: begin
        if (sp_flags.hit) begin
          state_nxt = pba_pkg::S_HIT;
        end else if (search_fail) begin
          state_nxt = tbl_pool_r ? pba_pkg::S_RD : pba_pkg::S_DONE;
        end else if (sp_flags.word_done) begin
          state_nxt = pba_pkg::S_RD;
        end
      end
      pba_pkg::S_HIT:  state_nxt = pba_pkg::S_HEND;
      pba_pkg::S_HEND: state_nxt = pba_pkg::S_MRD;
      pba_pkg::S_MRD:  state_nxt = pba_pkg::S_MWR;
      pba_pkg::S_MWR:  state_nxt = mark_last ? pba_pkg::S_DONE : pba_pkg::S_MRD;
      pba_pkg::S_PRD:  state_nxt = pba_pkg::S_PG;
      pba_pkg::S_PG:   state_nxt = pba_pkg::S_DONE;
      pba_pkg::S_DONE: begin
        if (done_load) begin
          state_nxt = pba_pkg::S_IDLE;
        end
      end
      default: state_nxt = pba_pkg::S_IDLE;
    endcase
  end

  // ram port and handshake outputs
  always_comb begin
    in_ready  = (state_r == pba_pkg::S_IDLE);
    ram_we    = 1'b0;
    ram_waddr = wi_r;
    ram_wdata = {rd_owner, rd_used};
    ram_re    = 1'b0;
    ram_raddr = wi_r;
    case (state_r)
      pba_pkg::S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = {{pba_pkg::WORD_W{1'b0}}, init_used};
      end
      pba_pkg::S_RD: begin
        ram_re = !scan_past;
      end
      pba_pkg::S_MRD: begin
        ram_re = 1'b1;
      end
      pba_pkg::S_MWR: begin
        ram_we    = 1'b1;
        ram_wdata = {owner_new, rd_used | run_mask};
      end
      pba_pkg::S_PRD: begin
        ram_re    = 1'b1;
        ram_raddr = pg_r[WIW+4:5];
      end
      pba_pkg::S_PG: begin
        ram_waddr = pg_r[WIW+4:5];
        ram_we    = (op_r == pba_pkg::OP_FREE) && rd_used[pg_r[4:0]];
        ram_wdata = {rd_owner, rd_used & ~(32'h1 << pg_r[4:0])};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // datapath updates
  always_comb begin
    op_nxt         = op_r;
    cnt_nxt        = cnt_r;
    pg_nxt         = pg_r;
    lo_nxt         = lo_r;
    hi_nxt         = hi_r;
    wi_nxt         = wi_r;
    pos_nxt        = pos_r;
    run_nxt        = run_r;
    start_nxt      = start_r;
    end_nxt        = end_r;
    tot_nxt        = tot_r;
    res_nxt        = res_r;
    usedend_nxt    = usedend_r;
    topstart_nxt   = topstart_r;
    managed_nxt    = managed_r;
    free_nxt       = free_r;
    pool_en_nxt    = pool_en_r;
    pool_first_nxt = pool_first_r;
    pool_end_nxt   = pool_end_r;
    tbl_pool_nxt   = tbl_pool_r;
    rs_status_nxt  = rs_status_r;
    rs_first_nxt   = rs_first_r;
    rs_user_nxt    = rs_user_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_first_nxt  = out_first_r;
    out_user_nxt   = out_user_r;
    out_free_nxt   = out_free_r;
    case (state_r)
      pba_pkg::S_IDLE: begin
        if (in_valid) begin
          op_nxt  = in_opcode;
          cnt_nxt = CW'(in_page_count);
          pg_nxt  = CW'(in_page_number);
        end
      end
      pba_pkg::S_DEC: begin
        rs_status_nxt = pba_pkg::ST_OK;
        rs_first_nxt  = '0;
        rs_user_nxt   = 1'b0;
        lo_nxt        = '0;
        hi_nxt        = managed_r;
        wi_nxt        = '0;
        run_nxt       = '0;
        tbl_pool_nxt  = 1'b0;
        case (op_r)
          pba_pkg::OP_INIT: begin
            tot_nxt = (CW'(cfg_total_r) > CW'(NUM_PAGES)) ? CW'(NUM_PAGES)
                                                          : CW'(cfg_total_r);
          end
          pba_pkg::OP_ALLOC_K,
          pba_pkg::OP_ALLOC_U: begin
            if (cnt_bad) begin
              rs_status_nxt = pba_pkg::ST_INVALID;
            end
          end
          pba_pkg::OP_ALLOC_TBL: begin
            cnt_nxt = CW'(1);
            if (pool_en_r) begin
              lo_nxt       = pool_first_r;
              hi_nxt       = tbl_hi;
              wi_nxt       = pool_first_r[WIW+4:5];
              tbl_pool_nxt = 1'b1;
            end
          end
          pba_pkg::OP_FREE,
          pba_pkg::OP_QUERY: begin
            if (pg_bad) begin
              rs_status_nxt = pba_pkg::ST_INVALID;
            end
          end
          default: rs_status_nxt = pba_pkg::ST_INVALID;
        endcase
      end
      pba_pkg::S_IRES: begin
        res_nxt = (CW'(cfg_res_r) > tot_r) ? tot_r : CW'(cfg_res_r);
      end
      pba_pkg::S_IPOOL: begin
        managed_nxt  = tot_r;
        topstart_nxt = (tot_r > CW'(TOP_RESERVED)) ? tot_r - CW'(TOP_RESERVED) : tot_r;
        if (pool_fit) begin
          pool_en_nxt    = 1'b1;
          pool_first_nxt = res_r;
          pool_end_nxt   = pool_sum[CW-1:0];
          usedend_nxt    = pool_sum[CW-1:0];
        end else begin
          pool_en_nxt    = 1'b0;
          pool_first_nxt = '0;
          pool_end_nxt   = '0;
          usedend_nxt    = res_r;
        end
      end
      pba_pkg::S_IFREE: begin
        // pages between the reserved and pool pages at the bottom and the top block stay free
        free_nxt = (topstart_r > usedend_r) ? topstart_r - usedend_r : '0;
        wi_nxt   = '0;
      end
      pba_pkg::S_INIT: begin
        wi_nxt = wi_r + WIW'(1);
      end
      pba_pkg::S_RD: begin
        pos_nxt = '0;
      end
      pba_pkg::S_SEG: begin
        if (!sp_flags.hit) begin
          run_nxt = sp_run;
          pos_nxt = sp_pos;
          if (sp_flags.word_done && !wi_last) begin
            wi_nxt = wi_r + WIW'(1);
          end
        end
      end
      pba_pkg::S_HIT: begin
        start_nxt = CW'({wi_r, pos_r}) - run_r;
      end
      pba_pkg::S_HEND: begin
        end_nxt      = start_r + cnt_r;
        free_nxt     = free_r - cnt_r;
        wi_nxt       = start_r[WIW+4:5];
        rs_first_nxt = start_r[15:0];
      end
      pba_pkg::S_MWR: begin
        wi_nxt = wi_r + WIW'(1);
      end
      pba_pkg::S_PG: begin
        if (op_r == pba_pkg::OP_FREE) begin
          if (rd_used[pg_r[4:0]]) begin
            free_nxt = free_r + CW'(1);
          end
        end else begin
          rs_user_nxt = rd_owner[pg_r[4:0]];
        end
      end
      pba_pkg::S_DONE: begin
        if (done_load) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = rs_status_r;
          out_first_nxt  = rs_first_r;
          out_user_nxt   = rs_user_r;
          out_free_nxt   = free_r[16:0];
        end
      end
      default: begin
        pos_nxt = pos_r;
      end
    endcase
    // a failed pool search falls back to one kernel page from page zero; other failed searches report out of memory
    if (search_fail) begin
      if (tbl_pool_r) begin
        lo_nxt       = '0;
        hi_nxt       = managed_r;
        wi_nxt       = '0;
        run_nxt      = '0;
        tbl_pool_nxt = 1'b0;
      end else if (op_r == pba_pkg::OP_ALLOC_U) begin
        rs_status_nxt = pba_pkg::ST_UOOM;
      end else if (op_r == pba_pkg::OP_ALLOC_TBL && pool_en_r) begin
        rs_status_nxt = pba_pkg::ST_TOOM;
      end else begin
        rs_status_nxt = pba_pkg::ST_KOOM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= pba_pkg::S_IDLE;
      cfg_total_r  <= 17'h10000;
      cfg_res_r    <= 17'h0;
      cfg_pool_r   <= 17'd4096;
      managed_r    <= '0;
      free_r       <= '0;
      pool_en_r    <= 1'b0;
      pool_first_r <= '0;
      pool_end_r   <= '0;
      tbl_pool_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      managed_r    <= managed_nxt;
      free_r       <= free_nxt;
      pool_en_r    <= pool_en_nxt;
      pool_first_r <= pool_first_nxt;
      pool_end_r   <= pool_end_nxt;
      tbl_pool_r   <= tbl_pool_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          pba_pkg::CFG_TOTAL:    cfg_total_r <= cfg_wdata;
          pba_pkg::CFG_RESERVED: cfg_res_r   <= cfg_wdata;
          pba_pkg::CFG_POOL:     cfg_pool_r  <= cfg_wdata;
          default:               cfg_total_r <= cfg_total_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    cnt_r        <= cnt_nxt;
    pg_r         <= pg_nxt;
    lo_r         <= lo_nxt;
    hi_r         <= hi_nxt;
    wi_r         <= wi_nxt;
    pos_r        <= pos_nxt;
    run_r        <= run_nxt;
    start_r      <= start_nxt;
    end_r        <= end_nxt;
    tot_r        <= tot_nxt;
    res_r        <= res_nxt;
    usedend_r    <= usedend_nxt;
    topstart_r   <= topstart_nxt;
    rs_status_r  <= rs_status_nxt;
    rs_first_r   <= rs_first_nxt;
    rs_user_r    <= rs_user_nxt;
    out_status_r <= out_status_nxt;
    out_first_r  <= out_first_nxt;
    out_user_r   <= out_user_nxt;
    out_free_r   <= out_free_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_first_page = out_first_r;
  assign out_owner_flag = out_user_r;
  assign out_free_pages = out_free_r;

endmodule

/* hw/rtl/pba_checker.sv */
// port-level checks of the page bitmap allocator, bound to the top level
// depends on pba_pkg and assert_macros.svh
`include "assert_macros.svh"

module pba_checker #(
  parameter int NUM_PAGES = 65536
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_first_page,
  input logic        out_owner_flag,
  input logic [16:0] out_free_pages
);

  // a held result keeps its status, first page and free count
  `PBA_ASSERT(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_first_page) && $stable(out_free_pages))

  `PBA_ASSERT_MSG(a_status_range, clk, rst_n,
    out_valid |-> out_status <= pba_pkg::ST_TOOM, "status code out of range")

  // failed requests report page zero and kernel owner
  `PBA_ASSERT_MSG(a_fail_clean, clk, rst_n,
    out_valid && out_status != pba_pkg::ST_OK |-> out_first_page == 16'h0 && !out_owner_flag,
    "failed item carries data")

  `PBA_ASSERT_MSG(a_free_bound, clk, rst_n,
    out_valid |-> 32'(out_free_pages) <= NUM_PAGES, "free count above page count")

  // in_ready is low in the cycle after an item is accepted
  `PBA_ASSERT(a_busy_after_accept, clk, rst_n, in_valid && in_ready |=> !in_ready)

endmodule

bind page_bitmap_allocator_core pba_checker #(.NUM_PAGES(NUM_PAGES)) u_pba_checker (.*);

/* test/tb_page_bitmap_allocator_core.sv */
// testbench for page_bitmap_allocator_core: directed and random requests,
// checked against an in-bench bitmap predictor; depends on pba_pkg and the core
`timescale 1ns / 100ps

module tb_page_bitmap_allocator_core;

  localparam int NPAGES     = 65536;
  localparam int TOP_RSV    = 16;
  localparam int STALL_MAX  = 1000000;
  localparam int RAND_ITEMS = 1300;

  typedef struct {
    pba_pkg::status_t status;
    logic [15:0]      first_page;
    logic             is_user;
    logic [16:0]      free_pages;
  } grant_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_opcode = pba_pkg::OP_INIT;
  logic [16:0] in_page_count = '0;
  logic [15:0] in_page_number = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_status;
  logic [15:0] out_first_page;
  logic        out_owner_flag;
  logic [16:0] out_free_pages;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = pba_pkg::CFG_TOTAL;
  logic [16:0] cfg_wdata = '0;

  page_bitmap_allocator_core DUT (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // allocator shadow
  bit          used_bits [NPAGES];
  bit          user_bits [NPAGES];
  int unsigned free_cnt, managed, pool_on, pool_lo, pool_hi;
  int unsigned reg_total = 65536, reg_reserved = 0, reg_pool = 4096;

  grant_t      pending_grants[$];
  int          snd_idle = 0, rcv_idle = 0;
  int          items_sent = 0;
  int          stall_cycles = 0;
  bit          failed = 1'b0;

  function automatic void claim(int unsigned p, bit owner);
    used_bits[p] = 1'b1;
    user_bits[p] = owner;
    free_cnt--;
  endfunction

  function automatic void shadow_init();
    int unsigned tot, res;
    tot = (reg_total > NPAGES) ? NPAGES : reg_total;
    res = (reg_reserved > tot) ? tot : reg_reserved;
    for (int i = 0; i < NPAGES; i++) begin
      used_bits[i] = 1'b0;
      user_bits[i] = 1'b0;
    end
    managed  = tot;
    free_cnt = tot;
    for (int unsigned i = 0; i < res; i++) claim(i, 1'b0);
    if (res != 0 && longint'(res) + longint'(reg_pool) < longint'(tot)) begin
      for (int unsigned i = res; i < res + reg_pool; i++) claim(i, 1'b0);
      pool_on = 1;
      pool_lo = res;
      pool_hi = res + reg_pool;
    end else begin
      pool_on = 0;
      pool_lo = 0;
      pool_hi = 0;
    end
    if (tot > TOP_RSV)
      for (int unsigned i = tot - TOP_RSV; i < tot; i++)
        if (!used_bits[i]) claim(i, 1'b0);
  endfunction

  // lowest-index first fit
  function automatic bit first_fit(int unsigned cnt, bit owner, output int unsigned start);
    int unsigned run;
    run = 0;
    start = 0;
    for (int unsigned i = 0; i < managed; i++) begin
      run = used_bits[i] ? 0 : run + 1;
      if (run == cnt) begin
        start = i + 1 - cnt;
        for (int unsigned j = start; j <= i; j++) claim(j, owner);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic grant_t predict_grant(logic [2:0] op, logic [16:0] cnt, logic [15:0] pg);
    grant_t      g;
    int unsigned start;
    bit          got;
    g.status = pba_pkg::ST_OK;
    g.first_page = '0;
    g.is_user = 1'b0;
    start = 0;
    got = 1'b0;
    case (op)
      pba_pkg::OP_INIT: shadow_init();
      pba_pkg::OP_ALLOC_K, pba_pkg::OP_ALLOC_U: begin
        if (cnt == 0 || cnt > managed) g.status = pba_pkg::ST_INVALID;
        else if (first_fit(cnt, op == pba_pkg::OP_ALLOC_U, start))
          g.first_page = start[15:0];
        else g.status = (op == pba_pkg::OP_ALLOC_U) ? pba_pkg::ST_UOOM : pba_pkg::ST_KOOM;
      end
      pba_pkg::OP_ALLOC_TBL: begin
        if (pool_on != 0)
          for (int unsigned i = pool_lo; i < pool_hi && i < managed; i++)
            if (!used_bits[i]) begin
              claim(i, 1'b0);
              g.first_page = i[15:0];
              got = 1'b1;
              break;
            end
        if (!got) begin
          if (first_fit(1, 1'b0, start)) g.first_page = start[15:0];
          else g.status = (pool_on != 0) ? pba_pkg::ST_TOOM : pba_pkg::ST_KOOM;
        end
      end
      pba_pkg::OP_FREE: begin
        if (pg >= managed) g.status = pba_pkg::ST_INVALID;
        else if (used_bits[pg]) begin
          used_bits[pg] = 1'b0;
          free_cnt++;
        end
      end
      pba_pkg::OP_QUERY: begin
        if (pg >= managed) g.status = pba_pkg::ST_INVALID;
        else g.is_user = user_bits[pg];
      end
      default: g.status = pba_pkg::ST_INVALID;
    endcase
    g.free_pages = free_cnt[16:0];
    return g;
  endfunction

  task automatic send_item(logic [2:0] op, logic [16:0] cnt, logic [15:0] pg);
    if ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_page_count  <= cnt;
    in_page_number <= pg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_grants.push_back(predict_grant(op, cnt, pg));
    items_sent++;
  endtask

  // drop valid first so the last item is not taken twice
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // called only while idle; the shadow reads the registers at init
  task automatic set_config(int unsigned tot, int unsigned res, int unsigned pool);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= pba_pkg::CFG_TOTAL;    cfg_wdata <= tot[16:0];
    @(posedge clk);
    cfg_index <= pba_pkg::CFG_RESERVED; cfg_wdata <= res[16:0];
    @(posedge clk);
    cfg_index <= pba_pkg::CFG_POOL;     cfg_wdata <= pool[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_total    = tot & 17'h1FFFF;
    reg_reserved = res & 17'h1FFFF;
    reg_pool     = pool & 17'h1FFFF;
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    grant_t g;
    if (rst_n && out_valid && out_ready) begin
      if (pending_grants.size() == 0) begin
        $error("item with no expectation: status %0d", out_status);
        failed = 1'b1;
      end else begin
        g = pending_grants.pop_front();
        if (out_status !== g.status) begin
          $error("status exp %0d got %0d", g.status, out_status);
          failed = 1'b1;
        end
        if (out_first_page !== g.first_page) begin
          $error("first_page exp %0d got %0d", g.first_page, out_first_page);
          failed = 1'b1;
        end
        if (out_owner_flag !== g.is_user) begin
          $error("is_user exp %0d got %0d", g.is_user, out_owner_flag);
          failed = 1'b1;
        end
        if (out_free_pages !== g.free_pages) begin
          $error("free_pages exp %0d got %0d", g.free_pages, out_free_pages);
          failed = 1'b1;
        end
      end
    end
    out_ready <= ($urandom_range(99) >= rcv_idle);
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles > STALL_MAX) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic test_before_init();
    send_item(pba_pkg::OP_ALLOC_K, 17'd1, 16'd0);
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);
    send_item(pba_pkg::OP_QUERY, 17'd0, 16'd0);
    send_item(pba_pkg::OP_FREE, 17'd0, 16'd0);
  endtask

  task automatic test_full_memory();
    set_config(65536, 0, 4096);
    send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
    send_item(pba_pkg::OP_ALLOC_K, 17'd1, 16'd0);         // page zero granted
    send_item(pba_pkg::OP_ALLOC_U, 17'd3, 16'd0);
    send_item(pba_pkg::OP_QUERY, 17'd0, 16'd2);
    send_item(pba_pkg::OP_ALLOC_U, 17'h10000, 16'd0);     // fits no run
    send_item(pba_pkg::OP_ALLOC_K, 17'h10000, 16'd0);
    send_item(pba_pkg::OP_ALLOC_K, 17'd0, 16'd0);         // zero count
    send_item(pba_pkg::OP_ALLOC_U, 17'h1FFFF, 16'hFFFF);  // count above managed
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);       // no pool: plain kernel page
    wait_drained();                                       // sender holds until all results are in
    send_item(pba_pkg::OP_FREE, 17'd0, 16'd2);
    send_item(pba_pkg::OP_FREE, 17'd0, 16'd2);            // already free
    send_item(pba_pkg::OP_FREE, 17'd0, 16'hFFFF);
    send_item(pba_pkg::OP_QUERY, 17'd0, 16'hFFFF);
    send_item(3'd6, 17'd5, 16'd1);
    send_item(3'd7, 17'h1FFFF, 16'hFFFF);
  endtask

  task automatic test_pool_and_limits();
    set_config(17'h1FFFF, 100, 200);                      // oversize total
    send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);
    send_item(pba_pkg::OP_FREE, 17'd0, 16'd150);
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);
    set_config(40, 4, 20);                                // pool 4..23, top 24..39
    send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);       // pool full and nothing free
    send_item(pba_pkg::OP_FREE, 17'd0, 16'd5);
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);
    send_item(pba_pkg::OP_FREE, 17'd0, 16'd40);           // out of range
    set_config(40, 50, 17'h1FFFF);                        // reserve beyond total
    send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
    send_item(pba_pkg::OP_ALLOC_K, 17'd1, 16'd0);
    set_config(10, 0, 0);                                 // small memory, no top reserve
    send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
    send_item(pba_pkg::OP_ALLOC_U, 17'd10, 16'd0);
    send_item(pba_pkg::OP_ALLOC_TBL, 17'd0, 16'd0);
    set_config(0, 0, 0);
    send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
    send_item(pba_pkg::OP_QUERY, 17'd0, 16'd0);
  endtask

  task automatic random_item(int unsigned lim);
    int unsigned r;
    logic [16:0] cnt;
    logic [15:0] pg;
    r   = $urandom_range(99);
    cnt = ($urandom_range(9) == 0) ? 17'($urandom_range(0, lim + 2))
                                   : 17'($urandom_range(1, 8));
    if ($urandom_range(19) == 0) cnt = 17'($urandom);
    pg  = (lim != 0) ? 16'($urandom_range(0, lim)) : 16'd0;
    if ($urandom_range(9) == 0) pg = 16'($urandom);
    if (r < 28)      send_item(pba_pkg::OP_ALLOC_K, cnt, pg);
    else if (r < 55) send_item(pba_pkg::OP_ALLOC_U, cnt, pg);
    else if (r < 67) send_item(pba_pkg::OP_ALLOC_TBL, cnt, pg);
    else if (r < 88) send_item(pba_pkg::OP_FREE, cnt, pg);
    else if (r < 97) send_item(pba_pkg::OP_QUERY, cnt, pg);
    else if (r < 98) send_item(pba_pkg::OP_INIT, cnt, pg);
    else             send_item(3'($urandom_range(6, 7)), cnt, pg);
  endtask

  task automatic test_random();
    int unsigned tot, res, pool, n, r, start;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      if (items_sent - start < RAND_ITEMS / 3) begin
        snd_idle = 35; rcv_idle = 70;
      end else if (items_sent - start < 2 * RAND_ITEMS / 3) begin
        snd_idle = 70; rcv_idle = 35;
      end else begin
        snd_idle = 0; rcv_idle = 0;
      end
      r = $urandom_range(9);
      if (r < 8) tot = $urandom_range(17, 600);
      else if (r < 9) tot = $urandom_range(0, 16);
      else tot = ($urandom_range(1) != 0) ? 65536 : 17'h1FFFF;
      res  = ($urandom_range(7) == 0) ? 17'($urandom) : $urandom_range(0, tot / 4 + 1);
      pool = ($urandom_range(7) == 0) ? 17'($urandom) : $urandom_range(0, tot / 4 + 1);
      set_config(tot, res, pool);
      send_item(pba_pkg::OP_INIT, 17'd0, 16'd0);
      n = (tot > 600) ? 15 : 70;
      repeat (n) random_item((tot > NPAGES) ? NPAGES - 1 : tot);
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    snd_idle = 35; rcv_idle = 70;
    test_before_init();
    test_full_memory();
    test_pool_and_limits();
    test_random();
    wait_drained();
    repeat (50) @(posedge clk);
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/pba_pkg.sv
hw/rtl/pba_ram.sv
hw/rtl/pba_span.sv
hw/rtl/page_bitmap_allocator_core.sv
hw/rtl/pba_checker.sv
test/tb_page_bitmap_allocator_core.sv
